// ===== design/nvqt_pkg.sv =====
`timescale 1ns / 1ps

package nvqt_pkg;

   // Default sizing of the table
   localparam int MAX_VERTICES_DEF = 64;
   localparam int COORD_WIDTH_DEF  = 16;

   // Fixed field widths
   localparam int OP_W     = 2;
   localparam int INDEX_W  = 7;
   localparam int VINDEX_W = 6;
   localparam int COUNT_W  = 7;

   // Operation codes carried by a request transaction
   typedef enum logic [OP_W-1:0] {
      OP_WRITE   = 2'd0,
      OP_READ    = 2'd1,
      OP_NEAREST = 2'd2,
      OP_RECT    = 2'd3
   } op_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_RESPOND,
      ST_SETUP,
      ST_SCAN,
      ST_FINAL
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;         // latch the request fields
      logic access;       // single-entry write or read
      logic init;         // clear the scan and load radius squared
      logic scan;         // run the scan pipeline
      logic emit_access;  // load the response of a write or read
      logic emit_final;   // load the closing response of a query
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic issue_done;   // every active entry has been read
      logic pipe_busy;    // reads still travel through the pipeline
      logic out_free;     // response register can take a value
   } status_type;

endpackage

// ===== design/nvqt_if.sv =====
`timescale 1ns / 1ps

interface nvqt_req_if #(
   parameter int COORD_WIDTH = nvqt_pkg::COORD_WIDTH_DEF
);
   import nvqt_pkg::*;

   logic                          valid;
   logic                          ready;
   op_type                        operation;
   logic [INDEX_W-1:0]            index;
   logic signed [COORD_WIDTH-1:0] pos_x;
   logic signed [COORD_WIDTH-1:0] pos_y;
   logic signed [COORD_WIDTH-1:0] bound_x;
   logic signed [COORD_WIDTH-1:0] bound_y;
   logic [COORD_WIDTH-1:0]        radius;

   modport source (
      output valid, operation, index, pos_x, pos_y, bound_x, bound_y, radius,
      input  ready
   );

   modport sink (
      input  valid, operation, index, pos_x, pos_y, bound_x, bound_y, radius,
      output ready
   );
endinterface

interface nvqt_rsp_if #(
   parameter int COORD_WIDTH = nvqt_pkg::COORD_WIDTH_DEF
);
   import nvqt_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [VINDEX_W-1:0]           vertex_index;
   logic signed [COORD_WIDTH-1:0] out_x;
   logic signed [COORD_WIDTH-1:0] out_y;
   logic                          last;

   modport source (
      output valid, found, vertex_index, out_x, out_y, last,
      input  ready
   );

   modport sink (
      input  valid, found, vertex_index, out_x, out_y, last,
      output ready
   );
endinterface

// ===== design/nvqt_ctrl.sv =====
`timescale 1ns / 1ps

module nvqt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  nvqt_pkg::op_type     req_op,
   input  nvqt_pkg::status_type status,
   output logic                 req_ready,
   output nvqt_pkg::cmd_type    cmd
);
   import nvqt_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Hold the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Pick the next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_op) inside
                  OP_WRITE, OP_READ:  state_in = ST_ACCESS;
                  OP_NEAREST, OP_RECT: state_in = ST_SETUP;
                  default:            state_in = ST_SETUP;
               endcase
            end
         end
         ST_ACCESS:  state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         ST_SETUP:   state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.issue_done && !status.pipe_busy) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // Drive commands for the current state
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_ACCESS:  cmd.access      = 1'b1;
         ST_RESPOND: cmd.emit_access = status.out_free;
         ST_SETUP:   cmd.init        = 1'b1;
         ST_SCAN:    cmd.scan        = 1'b1;
         ST_FINAL:   cmd.emit_final  = status.out_free;
         default:    cmd             = '0;
      endcase
   end

endmodule

// ===== design/nvqt_datapath.sv =====
`timescale 1ns / 1ps

module nvqt_datapath #(
   parameter int MAX_VERTICES = nvqt_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = nvqt_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [nvqt_pkg::COUNT_W-1:0]      csr_wr_data,
   input  nvqt_pkg::op_type                  req_operation,
   input  logic [nvqt_pkg::INDEX_W-1:0]      req_index,
   input  logic signed [COORD_WIDTH-1:0]     req_pos_x,
   input  logic signed [COORD_WIDTH-1:0]     req_pos_y,
   input  logic signed [COORD_WIDTH-1:0]     req_bound_x,
   input  logic signed [COORD_WIDTH-1:0]     req_bound_y,
   input  logic [COORD_WIDTH-1:0]            req_radius,
   input  nvqt_pkg::cmd_type                 cmd,
   output nvqt_pkg::status_type              status,
   nvqt_rsp_if.source                        rsp_bus
);
   import nvqt_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int DW    = 2 * CW + 1;

   // Count register and latched request
   logic [COUNT_W-1:0]   count_ff;
   op_type               op_ff;
   logic [INDEX_W-1:0]   idx_ff;
   logic signed [CW-1:0] px_ff;
   logic signed [CW-1:0] py_ff;
   logic signed [CW-1:0] bx_ff;
   logic signed [CW-1:0] by_ff;
   logic [CW-1:0]        rad_ff;

   // Vertex table, {y, x} per entry
   logic [2*CW-1:0]      mem [MAX_VERTICES];
   logic [2*CW-1:0]      rd_ff;

   // Scan pipeline
   logic [CNT_W-1:0]     addr_ff;
   logic [CNT_W-1:0]     n_cnt;
   logic                 s1_valid_ff;
   logic [AW-1:0]        s1_idx_ff;
   logic                 s2_valid_ff;
   logic                 s2_match_ff;
   logic [AW-1:0]        s2_idx_ff;
   logic signed [CW-1:0] s2_x_ff;
   logic signed [CW-1:0] s2_y_ff;
   logic [2*CW-1:0]      dx2_ff;
   logic [2*CW-1:0]      dy2_ff;

   // Best hit of a nearest query, or pending result of a rectangle query
   logic [DW-1:0]        best_ff;
   logic                 have_ff;
   logic [AW-1:0]        hit_idx_ff;
   logic signed [CW-1:0] hit_x_ff;
   logic signed [CW-1:0] hit_y_ff;

   // Response register
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic [VINDEX_W-1:0]  rsp_idx_ff;
   logic signed [CW-1:0] rsp_x_ff;
   logic signed [CW-1:0] rsp_y_ff;
   logic                 rsp_last_ff;

   logic                 idx_ok;
   logic                 out_free;
   logic                 advance;
   logic                 issue;
   logic                 spill;
   logic                 emit;
   logic                 rd_en;
   logic [AW-1:0]        acc_addr;
   logic [AW-1:0]        rd_addr;
   logic signed [CW-1:0] rd_x;
   logic signed [CW-1:0] rd_y;
   logic [CW:0]          dx;
   logic [CW:0]          dy;
   logic [CW:0]          dx_neg;
   logic [CW:0]          dy_neg;
   logic [CW-1:0]        mag_x;
   logic [CW-1:0]        mag_y;
   logic                 in_rect;
   logic [2*CW-1:0]      rad_sq;
   logic [DW-1:0]        d2;

   // Hold the vertex count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // Clamp the count to the table size
   always_comb begin
      if (CMP_W'(count_ff) > CMP_W'(MAX_VERTICES)) begin
         n_cnt = CNT_W'(MAX_VERTICES);
      end else begin
         n_cnt = CNT_W'(count_ff);
      end
   end

   assign idx_ok = CMP_W'(idx_ff) < CMP_W'(n_cnt);

   // Latch the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_operation;
         idx_ff <= req_index;
         px_ff  <= req_pos_x;
         py_ff  <= req_pos_y;
         bx_ff  <= req_bound_x;
         by_ff  <= req_bound_y;
         rad_ff <= req_radius;
      end
   end

   // Pipeline moves only when the response register can take a result
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign advance  = cmd.scan && out_free;
   assign issue    = advance && (addr_ff < n_cnt);

   // Table port: access reads at the request index, the scan at its counter
   assign acc_addr = AW'(idx_ff);
   assign rd_addr  = cmd.access ? acc_addr : addr_ff[AW-1:0];
   assign rd_en    = (cmd.access && (op_ff == OP_READ)) || issue;

   always_ff @(posedge clock) begin
      if (cmd.access && (op_ff == OP_WRITE) && idx_ok) begin
         mem[acc_addr] <= {py_ff, px_ff};
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_x = rd_ff[CW-1:0];
   assign rd_y = rd_ff[2*CW-1:CW];

   // Advance the scan counter and stage valids
   always_ff @(posedge clock) begin
      if (reset || cmd.init) begin
         addr_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         if (issue) addr_ff <= addr_ff + 1'b1;
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) s1_idx_ff <= addr_ff[AW-1:0];
   end

   // Absolute differences to the query point and box test
   assign dx     = {rd_x[CW-1], rd_x} - {px_ff[CW-1], px_ff};
   assign dy     = {rd_y[CW-1], rd_y} - {py_ff[CW-1], py_ff};
   assign dx_neg = -dx;
   assign dy_neg = -dy;
   assign mag_x  = dx[CW] ? dx_neg[CW-1:0] : dx[CW-1:0];
   assign mag_y  = dy[CW] ? dy_neg[CW-1:0] : dy[CW-1:0];
   assign in_rect = (rd_x >= px_ff) && (rd_x <= bx_ff) &&
                    (rd_y >= py_ff) && (rd_y <= by_ff);

   // Square the differences
   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         s2_idx_ff   <= s1_idx_ff;
         s2_x_ff     <= rd_x;
         s2_y_ff     <= rd_y;
         s2_match_ff <= in_rect;
         dx2_ff      <= mag_x * mag_x;
         dy2_ff      <= mag_y * mag_y;
      end
   end

   assign rad_sq = rad_ff * rad_ff;
   assign d2     = DW'(dx2_ff) + DW'(dy2_ff);

   // Spill the pending rectangle hit when a newer one arrives
   assign spill = advance && s2_valid_ff && (op_ff == OP_RECT) && s2_match_ff && have_ff;

   // Keep the strictly closest hit, or the latest box hit
   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (cmd.init) begin
         have_ff <= 1'b0;
         best_ff <= DW'(rad_sq);
      end else if (advance && s2_valid_ff) begin
         if (op_ff == OP_NEAREST) begin
            if (d2 < best_ff) begin
               best_ff    <= d2;
               have_ff    <= 1'b1;
               hit_idx_ff <= s2_idx_ff;
               hit_x_ff   <= s2_x_ff;
               hit_y_ff   <= s2_y_ff;
            end
         end else if (s2_match_ff) begin
            have_ff    <= 1'b1;
            hit_idx_ff <= s2_idx_ff;
            hit_x_ff   <= s2_x_ff;
            hit_y_ff   <= s2_y_ff;
         end
      end
   end

   // Response register
   assign emit = cmd.emit_access || cmd.emit_final || spill;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit) begin
         if (cmd.emit_access) begin
            rsp_found_ff <= idx_ok;
            rsp_idx_ff   <= idx_ok ? VINDEX_W'(idx_ff) : '0;
            rsp_x_ff     <= !idx_ok ? '0 : ((op_ff == OP_WRITE) ? px_ff : rd_x);
            rsp_y_ff     <= !idx_ok ? '0 : ((op_ff == OP_WRITE) ? py_ff : rd_y);
            rsp_last_ff  <= 1'b1;
         end else if (cmd.emit_final) begin
            rsp_found_ff <= have_ff;
            rsp_idx_ff   <= have_ff ? VINDEX_W'(hit_idx_ff) : '0;
            rsp_x_ff     <= have_ff ? hit_x_ff : '0;
            rsp_y_ff     <= have_ff ? hit_y_ff : '0;
            rsp_last_ff  <= 1'b1;
         end else begin
            rsp_found_ff <= 1'b1;
            rsp_idx_ff   <= VINDEX_W'(hit_idx_ff);
            rsp_x_ff     <= hit_x_ff;
            rsp_y_ff     <= hit_y_ff;
            rsp_last_ff  <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.found        = rsp_found_ff;
   assign rsp_bus.vertex_index = rsp_idx_ff;
   assign rsp_bus.out_x        = rsp_x_ff;
   assign rsp_bus.out_y        = rsp_y_ff;
   assign rsp_bus.last         = rsp_last_ff;

   // Report to the controller
   assign status.issue_done = (addr_ff == n_cnt);
   assign status.pipe_busy  = s1_valid_ff || s2_valid_ff;
   assign status.out_free   = out_free;

endmodule

// ===== design/nearest_vertex_query_table.sv =====
`timescale 1ns / 1ps
// Write and read: the request is latched, the table entry is written or read, and the result
// is loaded into the response register once it is free. Nearest and rectangle queries over n
// active vertices make one table read per cycle while the response register is free.
// One request is in flight at a time; a new one is taken while its last result waits.
// Reset (synchronous, active high) clears the vertex count and control; the table
// contents are not cleared and hold nothing defined until written.

module nearest_vertex_query_table #(
   parameter int MAX_VERTICES = nvqt_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = nvqt_pkg::COORD_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [nvqt_pkg::COUNT_W-1:0] csr_wr_data,
   nvqt_req_if.sink                     req_bus,
   nvqt_rsp_if.source                   rsp_bus
);
   import nvqt_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_bus.ready = req_ready;

   // Sequence each transaction
   nvqt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.operation),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // Table, scan pipeline and response register
   nvqt_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_operation (req_bus.operation),
      .req_index     (req_bus.index),
      .req_pos_x     (req_bus.pos_x),
      .req_pos_y     (req_bus.pos_y),
      .req_bound_x   (req_bus.bound_x),
      .req_bound_y   (req_bus.bound_y),
      .req_radius    (req_bus.radius),
      .cmd           (cmd),
      .status        (status),
      .rsp_bus       (rsp_bus)
   );

endmodule

// ===== design/nvqt_checker.sv =====
`timescale 1ns / 1ps

module nvqt_checker #(
   parameter int COORD_WIDTH = nvqt_pkg::COORD_WIDTH_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_found,
   input logic [nvqt_pkg::VINDEX_W-1:0] rsp_vertex_index,
   input logic signed [COORD_WIDTH-1:0] rsp_out_x,
   input logic signed [COORD_WIDTH-1:0] rsp_out_y,
   input logic                          rsp_last
);
   import nvqt_pkg::*;

   // Response register comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_vertex_index) && $stable(rsp_out_x) && $stable(rsp_out_y) &&
      $stable(rsp_last))
      else $error("stalled response changed");

   // A not-found response closes its transaction with cleared fields
   a_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && (rsp_vertex_index == '0) &&
      (rsp_out_x == '0) && (rsp_out_y == '0))
      else $error("not-found response malformed");

   // Only one transaction is worked on at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // More results follow a non-final one, so no new request is taken meanwhile
   a_burst_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken inside a result burst");

endmodule

bind nearest_vertex_query_table nvqt_checker #(
   .COORD_WIDTH (COORD_WIDTH)
) u_nvqt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_found        (rsp_bus.found),
   .rsp_vertex_index (rsp_bus.vertex_index),
   .rsp_out_x        (rsp_bus.out_x),
   .rsp_out_y        (rsp_bus.out_y),
   .rsp_last         (rsp_bus.last)
);
